// ----- hw/rtl/rttewma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttewma_pkg: shared types and constants of the delay estimator
// Word layouts, arithmetic widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package rttewma_pkg;

  // Timestamp and size widths
  localparam int TimeBits = 48;
  localparam int SizeBits = 16;

  // Reset value of the reference frame size
  localparam logic [SizeBits-1:0] RefSizeReset = SizeBits'(1518);

  // Half of the timestamp difference drops one bit
  localparam int HalfBits = TimeBits - 1;
  // Scaled product half * reference size
  localparam int ProdBits = HalfBits + SizeBits;
  // The multiply runs in two passes over the low and high part of the half delay
  localparam int MulLoBits = TimeBits / 2;
  localparam int MulHiBits = HalfBits - MulLoBits;
  localparam int MulResBits = MulLoBits + SizeBits;

  // One quotient bit per divide step
  localparam int DivSteps = TimeBits;
  localparam int CntBits = $clog2(DivSteps);

  // Input word: one acknowledgement event
  typedef struct packed {
    logic                ack_in_order;
    logic                send_info_lost;
    logic [TimeBits-1:0] ack_time_us;
    logic [TimeBits-1:0] send_time_us;
    logic [SizeBits-1:0] packet_bytes;
  } in_word_t;

  // Output word: estimates after the event
  typedef struct packed {
    logic [TimeBits-1:0] smoothed_delay;
    logic [TimeBits-1:0] delay_deviation;
    logic                reordered_flag;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic skip;
  } dp_status_t;

endpackage

// ----- hw/rtl/rttewma_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttewma_dp: estimator datapath
// Holds the reference size, the estimates, a shared multiplier, a restoring
// divider and the output word register.
// ----------------------------------------------------------------------------
module rttewma_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rttewma_pkg::in_word_t          in_word_i,
  input  logic                           cfg_we_i,
  input  logic [rttewma_pkg::SizeBits-1:0] cfg_wdata_i,
  input  rttewma_pkg::ctrl_cmd_t         cmd_i,
  output rttewma_pkg::dp_status_t        status_o,
  output rttewma_pkg::out_word_t         out_word_o
);
  import rttewma_pkg::*;

  logic [SizeBits-1:0]   ref_q;
  logic [TimeBits-1:0]   delay_q, delay_d;
  logic [TimeBits-1:0]   dev_q, dev_d;
  logic [HalfBits-1:0]   half_q;
  logic [SizeBits-1:0]   size_q;
  logic                  in_order_q;
  logic [ProdBits-1:0]   prod_q;
  logic [SizeBits-1:0]   rem_q;
  logic [TimeBits-1:0]   dvd_q;
  logic                  sat_q;
  out_word_t             out_word_q;

  logic [TimeBits-1:0]   time_diff;
  logic [MulLoBits-1:0]  mul_a;
  logic [MulResBits-1:0] mul_res;
  logic [SizeBits:0]     trial;
  logic                  trial_ge;
  logic [SizeBits:0]     trial_sub;
  logic [TimeBits-1:0]   sample;
  logic [TimeBits-1:0]   diff;
  logic [TimeBits-1:0]   dev_hi7;
  logic [5:0]            dev_lo7;
  logic [TimeBits-1:0]   rtt_hi3;
  logic [3:0]            rtt_lo3;

  // Items that leave the state alone
  assign status_o.skip = !in_word_i.ack_in_order || in_word_i.send_info_lost;

  // Wrapped timestamp difference; bits above bit 0 give the half delay
  assign time_diff = in_word_i.ack_time_us - in_word_i.send_time_us;

  // Shared multiplier: low part first, then high part
  assign mul_a   = cmd_i.mul_hi ? MulLoBits'(half_q[HalfBits-1:MulLoBits])
                                : half_q[MulLoBits-1:0];
  assign mul_res = mul_a * ref_q;

  // One restoring divide step
  assign trial     = {rem_q, dvd_q[TimeBits-1]};
  assign trial_ge  = trial >= {1'b0, size_q};
  assign trial_sub = trial - {1'b0, size_q};

  // Delay sample with its special cases
  always_comb begin
    if (ref_q == '0) begin
      sample = '0;
    end else if (size_q == '0 || sat_q) begin
      sample = '1;
    end else begin
      sample = dvd_q;
    end
  end

  // Smoothing filters
  assign diff    = (sample > delay_q) ? (sample - delay_q) : (delay_q - sample);
  assign dev_hi7 = (dev_q >> 3) * TimeBits'(7);
  assign dev_lo7 = dev_q[2:0] * 3'd7;
  assign rtt_hi3 = (delay_q >> 2) * TimeBits'(3);
  assign rtt_lo3 = delay_q[1:0] * 2'd3;

  always_comb begin
    delay_d = delay_q;
    dev_d   = dev_q;
    if (delay_q == '0) begin
      delay_d = sample;
    end else begin
      if (dev_q == '0) begin
        dev_d = diff;
      end else begin
        dev_d = dev_hi7 + TimeBits'(dev_lo7[5:3]) + (diff >> 3);
      end
      delay_d = rtt_hi3 + TimeBits'(rtt_lo3[3:2]) + (sample >> 2);
    end
  end

  // Configuration and estimate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= RefSizeReset;
      delay_q <= '0;
      dev_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        ref_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        delay_q <= delay_d;
        dev_q   <= dev_d;
      end
    end
  end

  // Working registers and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      half_q     <= time_diff[TimeBits-1:1];
      size_q     <= in_word_i.packet_bytes;
      in_order_q <= in_word_i.ack_in_order;
    end
    if (cmd_i.mul_lo) begin
      prod_q <= ProdBits'(mul_res);
    end
    if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (ProdBits'(mul_res) << MulLoBits);
    end
    if (cmd_i.div_init) begin
      sat_q <= {1'b0, prod_q[ProdBits-1:TimeBits]} >= size_q;
      rem_q <= {1'b0, prod_q[ProdBits-1:TimeBits]};
      dvd_q <= prod_q[TimeBits-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[SizeBits-1:0] : trial[SizeBits-1:0];
      dvd_q <= {dvd_q[TimeBits-2:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      out_word_q.smoothed_delay  <= delay_q;
      out_word_q.delay_deviation <= dev_q;
      out_word_q.reordered_flag  <= !in_order_q;
    end
  end

  assign out_word_o = out_word_q;

endmodule

// ----- hw/rtl/rttewma_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttewma_ctrl: estimator controller
// Sequences accept, two-pass multiply, divider set-up, divide steps, filter
// update and hand-off to the output register; skipped words go to hand-off.
// ----------------------------------------------------------------------------
module rttewma_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  rttewma_pkg::dp_status_t status_i,
  output rttewma_pkg::ctrl_cmd_t  cmd_o
);
  import rttewma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_INIT,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_e;

  state_e             state_q;
  logic [CntBits-1:0] cnt_q;
  logic               out_valid_q;
  logic               out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  // Output register can take a word when empty or being drained
  assign out_free    = !out_valid_q || !out_stall_i;

  // Decode commands from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = state_q == S_IDLE && in_valid_i;
    cmd_o.mul_lo   = state_q == S_MUL_LO;
    cmd_o.mul_hi   = state_q == S_MUL_HI;
    cmd_o.div_init = state_q == S_DIV_INIT;
    cmd_o.div_step = state_q == S_DIV;
    cmd_o.update   = state_q == S_UPDATE;
    cmd_o.load_out = state_q == S_FINISH && out_free;
  end

  // Advance the sequence and track the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Set on hand-off, clear once the word is taken
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= status_i.skip ? S_FINISH : S_MUL_LO;
          end
        end
        S_MUL_LO:   state_q <= S_MUL_HI;
        S_MUL_HI:   state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(DivSteps - 1)) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE:   state_q <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rtt_ewma_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_ewma_estimator: smoothed one-way delay and deviation estimator
// Scales each delay sample to a reference frame size and keeps integer
// exponentially weighted averages of delay and deviation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o | in_word_i  (in_word_t)
//  out     | output    | out_valid_o/ out_stall_i| out_word_o (out_word_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (reference size)
//
//  A sample word runs from accept to next accept through two multiply passes,
//  divider set-up, 48 restoring divide steps (one quotient bit per cycle),
//  filter update and hand-off. A reordered or lost-send word skips to hand-off.
//  Reset clears the estimates and loads the reference size with 1518.
//  The result sits in an output register; the block takes the next word while
//  it waits, and stalls only if a second result is due before it is taken.
// ----------------------------------------------------------------------------
module rtt_ewma_estimator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rttewma_pkg::in_word_t            in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rttewma_pkg::out_word_t           out_word_o,
  input  logic                             cfg_we_i,
  input  logic [rttewma_pkg::SizeBits-1:0] cfg_wdata_i
);
  import rttewma_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rttewma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rttewma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- hw/rtl/rttewma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttewma_checker: port-level checks of the estimator
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rttewma_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input rttewma_pkg::out_word_t out_word_o
);
  import rttewma_pkg::*;

  // Output word is empty while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled output word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // One word at a time: the input stalls right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted back to back");

  // No result appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind rtt_ewma_estimator rttewma_checker u_rttewma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
